// ===== hdl/assert_macros.svh =====
// assertion macros shared by the tracker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define GCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition holds in the cycle after a trigger
`define GCT_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ===== hdl/gct_pkg.sv =====
// types and constants of the greedy centroid tracker
package gct_pkg;

  localparam int unsigned TRACK_SLOTS_DEF    = 16;
  localparam int unsigned MAX_DETECTIONS_DEF = 16;

  localparam logic [13:0] ID_TOP       = 14'd9999;
  localparam logic [9:0]  RADIUS_FLOOR = 10'd8;
  localparam logic [9:0]  RADIUS_RST   = 10'd32;
  localparam logic [7:0]  LOST_RST     = 8'd5;

  // floor(v / 3) for v below 4096 as (v * 2731) >> 13
  localparam logic [12:0] RECIP3       = 13'd2731;

  localparam logic [1:0] CFG_MATCH_RADIUS = 2'd0;
  localparam logic [1:0] CFG_LOST_LIMIT   = 2'd1;

  typedef struct packed {
    logic [19:0] area;
    logic [9:0]  h;
    logic [9:0]  w;
    logic [9:0]  y;
    logic [9:0]  x;
  } det_t;

  typedef struct packed {
    logic [13:0] id;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [9:0]  w;
    logic [9:0]  h;
    logic [19:0] area;
    logic [15:0] age;
    logic [7:0]  lost;
  } slot_t;

endpackage

// ===== hdl/greedy_centroid_tracker_core.sv =====
// greedy nearest-neighbor centroid tracker core
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o   | op, det_x/y/width/height/area
//  out     | output    | out_valid_o/out_ready_i | track fields, active_count, last
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// a detection request is written to the detection memory while it has
// room; an end-of-frame request runs the update through the slot and
// detection memories: each active track and detection pair goes
// through the distance unit, each active track is updated, idle slots
// are skipped and new tracks are opened, then results are emitted
// reset clears the active bits and counters and loads the config defaults; no clearing pass
// a stalled output holds the sequencer in its emit state, or in its start state for an empty table
module greedy_centroid_tracker_core
  import gct_pkg::*;
#(
  parameter int unsigned TRACK_SLOTS    = TRACK_SLOTS_DEF,
  parameter int unsigned MAX_DETECTIONS = MAX_DETECTIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [9:0]  det_x_i,
  input  logic [9:0]  det_y_i,
  input  logic [9:0]  det_width_i,
  input  logic [9:0]  det_height_i,
  input  logic [19:0] det_area_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        track_valid_o,
  output logic [13:0] track_id_o,
  output logic [9:0]  track_x_o,
  output logic [9:0]  track_y_o,
  output logic [9:0]  track_width_o,
  output logic [9:0]  track_height_o,
  output logic [19:0] track_area_o,
  output logic [15:0] track_age_o,
  output logic [7:0]  frames_lost_o,
  output logic [4:0]  active_count_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

`include "assert_macros.svh"

  localparam int unsigned SW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int unsigned TW = $clog2(TRACK_SLOTS + 1);
  localparam int unsigned DW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_DETECTIONS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TRK, S_DRD, S_DSQ, S_DCMP, S_MUPD, S_MRD, S_MWR,
    S_NEW, S_NRD, S_NWR, S_OSTART, S_OSCAN, S_ORD, S_OEMIT
  } state_e;

  state_e state_q;

  slot_t slot_mem [TRACK_SLOTS];
  det_t  det_mem  [MAX_DETECTIONS];
  slot_t slot_rdata_q;
  det_t  det_rdata_q;

  logic              slot_we;
  logic [SW-1:0]     slot_waddr;
  slot_t             slot_wdata;
  logic [SW-1:0]     slot_raddr;
  logic              det_we;
  logic [DW-1:0]     det_waddr;
  det_t              det_wdata;
  logic [DW-1:0]     det_raddr;

  logic [TRACK_SLOTS-1:0]    active_q;
  logic [MAX_DETECTIONS-1:0] used_q;
  logic [CW-1:0]             det_count_q;
  logic [TW-1:0]             t_q;
  logic [CW-1:0]             d_q;
  logic [DW-1:0]             best_q;
  logic [20:0]               best_dd_q;
  logic                      found_q;
  logic [19:0]               sqx_q, sqy_q;
  logic [19:0]               r2_q;
  logic [SW-1:0]             fs_q;
  logic [13:0]               next_ident_q;
  logic [TW-1:0]             cnt_q, k_q;
  logic [9:0]                radius_q;
  logic [7:0]                limit_q;

  logic out_valid_q;
  slot_t out_q;
  logic out_tv_q, out_last_q;
  logic [TW-1:0] out_cnt_q;

  // combinational helpers
  logic [9:0]  reff;
  logic [9:0]  dx, dy;
  logic [20:0] dd;
  logic [11:0] vx, vy;
  logic [24:0] px, py;
  logic [7:0]  lost_n;
  logic [15:0] age_n;
  logic        free_any;
  logic [SW-1:0] free_idx;
  logic [TW-1:0] active_num;
  logic        out_free;
  logic        out_set;
  logic        in_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  // a result is loaded into the output register this cycle
  assign out_set     = out_free && ((state_q == S_OEMIT) ||
                                    (state_q == S_OSTART && active_num == '0));

  assign reff = (radius_q < RADIUS_FLOOR) ? RADIUS_FLOOR : radius_q;
  assign dx = (det_rdata_q.x > slot_rdata_q.x) ? det_rdata_q.x - slot_rdata_q.x
                                                : slot_rdata_q.x - det_rdata_q.x;
  assign dy = (det_rdata_q.y > slot_rdata_q.y) ? det_rdata_q.y - slot_rdata_q.y
                                                : slot_rdata_q.y - det_rdata_q.y;
  assign dd = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign vx = {1'b0, slot_rdata_q.x, 1'b0} + {2'b00, det_rdata_q.x};
  assign vy = {1'b0, slot_rdata_q.y, 1'b0} + {2'b00, det_rdata_q.y};
  assign px = vx * RECIP3;
  assign py = vy * RECIP3;
  assign lost_n = (slot_rdata_q.lost == 8'hFF) ? 8'hFF : slot_rdata_q.lost + 8'd1;
  assign age_n  = (slot_rdata_q.age == 16'hFFFF) ? 16'hFFFF : slot_rdata_q.age + 16'd1;
  assign active_num = TW'($countones(active_q));

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TRACK_SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // memory port control
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = t_q[SW-1:0];
    slot_wdata = slot_rdata_q;
    slot_raddr = t_q[SW-1:0];
    det_we     = 1'b0;
    det_waddr  = det_count_q[DW-1:0];
    det_wdata  = '{area: det_area_i, h: det_height_i, w: det_width_i,
                   y: det_y_i, x: det_x_i};
    det_raddr  = (state_q == S_MRD || state_q == S_MWR) ? best_q : d_q[DW-1:0];
    unique case (state_q)
      S_IDLE: begin
        det_we = in_acc && !op_i && (det_count_q < CW'(MAX_DETECTIONS));
      end
      S_MWR: begin
        slot_we = 1'b1;
        if (found_q) begin
          slot_wdata.x    = px[22:13];
          slot_wdata.y    = py[22:13];
          slot_wdata.w    = det_rdata_q.w;
          slot_wdata.h    = det_rdata_q.h;
          slot_wdata.area = det_rdata_q.area;
          slot_wdata.age  = age_n;
          slot_wdata.lost = 8'd0;
        end else begin
          slot_wdata.lost = lost_n;
        end
      end
      S_NWR: begin
        slot_we    = 1'b1;
        slot_waddr = fs_q;
        slot_wdata = '{id: next_ident_q, x: det_rdata_q.x, y: det_rdata_q.y,
                       w: det_rdata_q.w, h: det_rdata_q.h, area: det_rdata_q.area,
                       age: 16'd1, lost: 8'd0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rdata_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (det_we) det_mem[det_waddr] <= det_wdata;
    det_rdata_q <= det_mem[det_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      limit_q  <= LOST_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MATCH_RADIUS: radius_q <= cfg_data_i;
        CFG_LOST_LIMIT:   limit_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      active_q     <= '0;
      used_q       <= '0;
      det_count_q  <= '0;
      t_q          <= '0;
      d_q          <= '0;
      best_q       <= '0;
      best_dd_q    <= '0;
      found_q      <= 1'b0;
      sqx_q        <= '0;
      sqy_q        <= '0;
      fs_q         <= '0;
      next_ident_q <= 14'd1;
      cnt_q        <= '0;
      k_q          <= '0;
      r2_q         <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      out_tv_q     <= 1'b0;
      out_cnt_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_set) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (!op_i) begin
              if (det_count_q < CW'(MAX_DETECTIONS)) det_count_q <= det_count_q + 1'b1;
            end else begin
              r2_q    <= reff * reff;
              t_q     <= '0;
              used_q  <= '0;
              state_q <= S_TRK;
            end
          end
        end
        S_TRK: begin
          if (t_q == TW'(TRACK_SLOTS)) begin
            d_q     <= '0;
            state_q <= S_NEW;
          end else if (!active_q[t_q[SW-1:0]]) begin
            t_q <= t_q + 1'b1;
          end else begin
            d_q     <= '0;
            found_q <= 1'b0;
            state_q <= (det_count_q != '0) ? S_DRD : S_MUPD;
          end
        end
        S_DRD: state_q <= S_DSQ;
        S_DSQ: begin
          sqx_q   <= dx * dx;
          sqy_q   <= dy * dy;
          state_q <= S_DCMP;
        end
        S_DCMP: begin
          if (!used_q[d_q[DW-1:0]] && dd <= {1'b0, r2_q} && (!found_q || dd < best_dd_q)) begin
            found_q   <= 1'b1;
            best_dd_q <= dd;
            best_q    <= d_q[DW-1:0];
          end
          if (d_q + 1'b1 == det_count_q) begin
            state_q <= S_MUPD;
          end else begin
            d_q     <= d_q + 1'b1;
            state_q <= S_DRD;
          end
        end
        S_MUPD: state_q <= found_q ? S_MRD : S_MWR;
        S_MRD:  state_q <= S_MWR;
        S_MWR: begin
          if (found_q) used_q[best_q] <= 1'b1;
          else if (lost_n > limit_q) active_q[t_q[SW-1:0]] <= 1'b0;
          t_q     <= t_q + 1'b1;
          state_q <= S_TRK;
        end
        S_NEW: begin
          if (d_q == det_count_q || !free_any) begin
            state_q <= S_OSTART;
          end else if (used_q[d_q[DW-1:0]]) begin
            d_q <= d_q + 1'b1;
          end else begin
            fs_q    <= free_idx;
            state_q <= S_NRD;
          end
        end
        S_NRD: state_q <= S_NWR;
        S_NWR: begin
          active_q[fs_q] <= 1'b1;
          next_ident_q   <= (next_ident_q >= ID_TOP) ? 14'd1 : next_ident_q + 14'd1;
          d_q            <= d_q + 1'b1;
          state_q        <= S_NEW;
        end
        S_OSTART: begin
          det_count_q <= '0;
          cnt_q       <= active_num;
          t_q         <= '0;
          k_q         <= '0;
          if (active_num != '0) begin
            state_q <= S_OSCAN;
          end else if (out_free) begin
            // empty table: a single result with the valid flag clear
            out_q       <= '0;
            out_tv_q    <= 1'b0;
            out_cnt_q   <= '0;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_OSCAN: begin
          if (t_q == TW'(TRACK_SLOTS)) state_q <= S_IDLE;
          else if (active_q[t_q[SW-1:0]]) state_q <= S_ORD;
          else t_q <= t_q + 1'b1;
        end
        S_ORD: state_q <= S_OEMIT;
        S_OEMIT: begin
          if (out_free) begin
            out_q       <= slot_rdata_q;
            out_tv_q    <= 1'b1;
            out_cnt_q   <= cnt_q;
            out_last_q  <= (k_q + 1'b1 == cnt_q);
            k_q         <= k_q + 1'b1;
            t_q         <= t_q + 1'b1;
            state_q     <= (k_q + 1'b1 == cnt_q) ? S_IDLE : S_OSCAN;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign track_valid_o  = out_tv_q;
  assign track_id_o     = out_q.id;
  assign track_x_o      = out_q.x;
  assign track_y_o      = out_q.y;
  assign track_width_o  = out_q.w;
  assign track_height_o = out_q.h;
  assign track_area_o   = out_q.area;
  assign track_age_o    = out_q.age;
  assign frames_lost_o  = out_q.lost;
  assign active_count_o = 5'(out_cnt_q);
  assign last_o         = out_last_q;

  `GCT_ASSERT(a_det_count_bound, det_count_q <= CW'(MAX_DETECTIONS), "det count overflow")
  `GCT_ASSERT(a_ident_range, next_ident_q != 14'd0 && next_ident_q <= ID_TOP, "bad next id")
  `GCT_ASSERT(a_empty_is_last, !(out_valid_o && !track_valid_o) || last_o, "empty not last")
  `GCT_ASSERT(a_count_nonzero, !(out_valid_o && track_valid_o) || active_count_o != 5'd0,
              "track with zero count")
  `GCT_ASSERT_NEXT(a_frame_clears, state_q == S_OSTART, det_count_q == '0,
                   "det buffer not emptied")

endmodule
